@@ sv/dpfm_pkg.sv @@
// Constants, codes and widths shared by the demand paging frame manager.
`default_nettype none
package dpfm_pkg;
    localparam int NUM_PROCS       = 16;
    localparam int PAGES_PER_PROC  = 2048;
    localparam int NUM_FRAMES      = 4096;
    localparam int ESSENTIAL_PAGES = 10;

    localparam int ESS_COUNT = (ESSENTIAL_PAGES < PAGES_PER_PROC) ?
                               ESSENTIAL_PAGES : PAGES_PER_PROC;

    // port field widths
    localparam int REQ_FW    = 2;
    localparam int PROC_FW   = 4;
    localparam int PAGE_FW   = 11;
    localparam int STATUS_FW = 3;
    localparam int FRAME_FW  = 12;
    localparam int FCNT_FW   = 13;
    localparam int CNT_W     = 32;

    // internal widths
    localparam int PROC_W    = $clog2(NUM_PROCS);
    localparam int PAGE_W    = $clog2(PAGES_PER_PROC);
    localparam int FRAME_W   = $clog2(NUM_FRAMES);
    localparam int FCNT_W    = FRAME_W + 1;
    localparam int PT_ADDR_W = PROC_W + PAGE_W;
    localparam int PT_DEPTH  = NUM_PROCS * PAGES_PER_PROC;
    localparam int PT_W      = FRAME_W + 1;
    localparam int IDX_W     = PAGE_W + 1;
    localparam int SWQ_CW    = PROC_W + 1;

    // request codes
    localparam logic [REQ_FW-1:0] REQ_ACCESS  = 2'd0;
    localparam logic [REQ_FW-1:0] REQ_ADMIT   = 2'd1;
    localparam logic [REQ_FW-1:0] REQ_FINISH  = 2'd2;
    // unused code, answered as ignored
    localparam logic [REQ_FW-1:0] REQ_IGNORED = 2'd3;

    // result status codes
    localparam logic [STATUS_FW-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_FW-1:0] ST_FAULT    = 3'd1;
    localparam logic [STATUS_FW-1:0] ST_SWAPOUT  = 3'd2;
    localparam logic [STATUS_FW-1:0] ST_ADMITTED = 3'd3;
    localparam logic [STATUS_FW-1:0] ST_REFUSED  = 3'd4;
    localparam logic [STATUS_FW-1:0] ST_FINISHED = 3'd5;
    localparam logic [STATUS_FW-1:0] ST_SWAPIN   = 3'd6;
    localparam logic [STATUS_FW-1:0] ST_INACTIVE = 3'd7;
endpackage
`default_nettype wire

@@ sv/dpfm_ram.sv @@
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none
module dpfm_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/demand_paging_frame_manager.sv @@
// Demand paging frame manager: sequencer around page table and free frame RAMs.
//
// Usage: drive i_req_type, i_proc_id, i_page_index and raise start; the request
// is taken at a rising edge where start is high and busy is low. Each result
// appears on the o_ ports for one cycle with o_valid high; o_last marks the
// final result of a request (a finish that swaps a process back in gives two).
// The receiver cannot stall; results must be taken when o_valid is high.
// Each result is registered from the state that decides it:
//   rejected or ignored requests: decided in the idle state,
//   hits and mapped faults: decided in the page table read state,
//   admit: ESS_COUNT page table writes, each after a free frame RAM read,
//   alternating S_MAP_RD and S_MAP_WR,
//   finish or swap-out: a walk of the process's page table row (one
//   entry a cycle through the page table RAM), plus a swap-in map if any.
// After reset the block stays busy while it clears the page table and loads
// the free frame queue.
`default_nettype none
module demand_paging_frame_manager (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dpfm_pkg::REQ_FW-1:0]   i_req_type,
    input  wire logic [dpfm_pkg::PROC_FW-1:0]  i_proc_id,
    input  wire logic [dpfm_pkg::PAGE_FW-1:0]  i_page_index,
    output logic                               o_valid,
    output logic [dpfm_pkg::STATUS_FW-1:0]     o_status,
    output logic [dpfm_pkg::PROC_FW-1:0]       o_proc_out,
    output logic [dpfm_pkg::FRAME_FW-1:0]      o_frame_out,
    output logic [dpfm_pkg::FCNT_FW-1:0]       o_free_count,
    output logic [dpfm_pkg::CNT_W-1:0]         o_access_count,
    output logic [dpfm_pkg::CNT_W-1:0]         o_fault_count,
    output logic [dpfm_pkg::CNT_W-1:0]         o_swap_count,
    output logic                               o_last
);
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_REL    = 3'd3;
    localparam logic [2:0] S_MAP_RD = 3'd4;
    localparam logic [2:0] S_MAP_WR = 3'd5;

    localparam int PW  = dpfm_pkg::PROC_W;
    localparam int GW  = dpfm_pkg::PAGE_W;
    localparam int FW  = dpfm_pkg::FRAME_W;
    localparam int CW  = dpfm_pkg::FCNT_W;
    localparam int AW  = dpfm_pkg::PT_ADDR_W;
    localparam int TW  = dpfm_pkg::PT_W;
    localparam int XW  = dpfm_pkg::IDX_W;
    localparam int QW  = dpfm_pkg::SWQ_CW;
    localparam int NCW = dpfm_pkg::CNT_W;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_init, n_init;
    logic [1:0]    r_req, n_req;
    logic [PW-1:0] r_p, n_p;
    logic [GW-1:0] r_pg, n_pg;
    logic [XW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [GW-1:0] r_paddr, n_paddr;
    logic [FW-1:0] r_fhead, n_fhead;
    logic [CW-1:0] r_fcnt, n_fcnt;
    logic [PW-1:0] r_swq [dpfm_pkg::NUM_PROCS];
    logic [PW-1:0] r_swhead, n_swhead;
    logic [QW-1:0] r_swcnt, n_swcnt;
    logic          swq_we;
    logic [dpfm_pkg::NUM_PROCS-1:0] r_act, n_act, r_wait, n_wait;
    logic [NCW-1:0] r_acc, n_acc, r_flt, n_flt, r_swp, n_swp;

    logic                              r_ov;
    logic [dpfm_pkg::STATUS_FW-1:0]    r_ost;
    logic [PW-1:0]                     r_op;
    logic [FW-1:0]                     r_ofr;
    logic                              r_olast;
    logic                              e_valid, e_last;
    logic [dpfm_pkg::STATUS_FW-1:0]    e_status;
    logic [PW-1:0]                     e_proc;
    logic [FW-1:0]                     e_frame;

    logic          pt_we;
    logic [AW-1:0] pt_waddr, pt_raddr;
    logic [TW-1:0] pt_wdata, pt_rdata;
    logic          ff_we;
    logic [FW-1:0] ff_waddr, ff_wdata, ff_rdata;
    logic [FW-1:0] ftail;
    logic [PW-1:0] in_p;

    dpfm_ram #(.W(TW), .DEPTH(dpfm_pkg::PT_DEPTH)) u_pt (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_waddr), .i_wdata(pt_wdata),
        .i_raddr(pt_raddr), .o_rdata(pt_rdata)
    );

    // free frame queue is always read at its head
    dpfm_ram #(.W(FW), .DEPTH(dpfm_pkg::NUM_FRAMES)) u_free (
        .i_clk(i_clk), .i_we(ff_we), .i_waddr(ff_waddr), .i_wdata(ff_wdata),
        .i_raddr(r_fhead), .o_rdata(ff_rdata)
    );

    assign ftail = r_fhead + r_fcnt[FW-1:0];
    assign in_p  = i_proc_id[PW-1:0];
    assign busy  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;  n_init = r_init;  n_req = r_req;  n_p = r_p;
        n_pg = r_pg;  n_idx = r_idx;  n_pend = 1'b0;  n_paddr = r_paddr;
        n_fhead = r_fhead;  n_fcnt = r_fcnt;  n_swhead = r_swhead;
        n_swcnt = r_swcnt;  swq_we = 1'b0;  n_act = r_act;  n_wait = r_wait;
        n_acc = r_acc;  n_flt = r_flt;  n_swp = r_swp;
        e_valid = 1'b0;  e_last = 1'b1;  e_status = dpfm_pkg::ST_INACTIVE;
        e_proc = r_p;  e_frame = '0;
        pt_we = 1'b0;  pt_waddr = {r_p, r_pg};  pt_wdata = '0;
        pt_raddr = {in_p, i_page_index[GW-1:0]};
        ff_we = 1'b0;  ff_waddr = ftail;  ff_wdata = '0;

        unique case (r_state)
            S_INIT: begin
                pt_we    = 1'b1;
                pt_waddr = r_init;
                if (r_init < AW'(dpfm_pkg::NUM_FRAMES)) begin
                    ff_we    = 1'b1;
                    ff_waddr = r_init[FW-1:0];
                    ff_wdata = r_init[FW-1:0];
                end
                n_init = r_init + 1'b1;
                if (r_init == AW'(dpfm_pkg::PT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req_type;
                    n_p    = in_p;
                    n_pg   = i_page_index[GW-1:0];
                    e_proc = in_p;
                    n_idx  = '0;
                    unique case (i_req_type)
                        dpfm_pkg::REQ_ACCESS: begin
                            if (!r_act[in_p]) begin
                                e_valid = 1'b1;
                            end else begin
                                n_acc   = r_acc + 1'b1;
                                n_state = S_ACC;
                            end
                        end
                        dpfm_pkg::REQ_ADMIT: begin
                            if (r_act[in_p] || r_wait[in_p] ||
                                r_fcnt < CW'(dpfm_pkg::ESS_COUNT)) begin
                                e_valid  = 1'b1;
                                e_status = dpfm_pkg::ST_REFUSED;
                            end else begin
                                n_state = S_MAP_RD;
                            end
                        end
                        dpfm_pkg::REQ_FINISH: begin
                            if (!r_act[in_p]) begin
                                e_valid = 1'b1;
                            end else begin
                                n_act[in_p] = 1'b0;
                                n_state     = S_REL;
                            end
                        end
                        default: e_valid = 1'b1;
                    endcase
                end
            end
            S_ACC: begin
                if (pt_rdata[TW-1]) begin
                    e_valid  = 1'b1;
                    e_status = dpfm_pkg::ST_HIT;
                    e_frame  = pt_rdata[FW-1:0];
                    n_state  = S_IDLE;
                end else begin
                    n_flt = r_flt + 1'b1;
                    if (r_fcnt != '0) begin
                        pt_we    = 1'b1;
                        pt_wdata = {1'b1, ff_rdata};
                        n_fhead  = r_fhead + 1'b1;
                        n_fcnt   = r_fcnt - 1'b1;
                        e_valid  = 1'b1;
                        e_status = dpfm_pkg::ST_FAULT;
                        e_frame  = ff_rdata;
                        n_state  = S_IDLE;
                    end else begin
                        n_act[r_p] = 1'b0;
                        n_state    = S_REL;
                    end
                end
            end
            S_REL: begin
                // walk the row: read one entry a cycle, free it the next
                pt_raddr = {r_p, r_idx[GW-1:0]};
                if (r_idx < XW'(dpfm_pkg::PAGES_PER_PROC)) begin
                    n_idx   = r_idx + 1'b1;
                    n_pend  = 1'b1;
                    n_paddr = r_idx[GW-1:0];
                end
                if (r_pend && pt_rdata[TW-1]) begin
                    pt_we    = 1'b1;
                    pt_waddr = {r_p, r_paddr};
                    if (r_fcnt < CW'(dpfm_pkg::NUM_FRAMES)) begin
                        ff_we    = 1'b1;
                        ff_wdata = pt_rdata[FW-1:0];
                        n_fcnt   = r_fcnt + 1'b1;
                    end
                end
                if (r_idx == XW'(dpfm_pkg::PAGES_PER_PROC) && !r_pend) begin
                    e_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_req == dpfm_pkg::REQ_ACCESS) begin
                        e_status = dpfm_pkg::ST_SWAPOUT;
                        n_swp    = r_swp + 1'b1;
                        if (r_swcnt < QW'(dpfm_pkg::NUM_PROCS)) begin
                            swq_we      = 1'b1;
                            n_swcnt     = r_swcnt + 1'b1;
                            n_wait[r_p] = 1'b1;
                        end
                    end else begin
                        e_status = dpfm_pkg::ST_FINISHED;
                        if (r_fcnt >= CW'(dpfm_pkg::ESS_COUNT) && r_swcnt != '0) begin
                            e_last   = 1'b0;
                            n_p      = r_swq[r_swhead];
                            n_wait[r_swq[r_swhead]] = 1'b0;
                            n_swhead = r_swhead + 1'b1;
                            n_swcnt  = r_swcnt - 1'b1;
                            n_idx    = '0;
                            n_state  = S_MAP_RD;
                        end
                    end
                end
            end
            S_MAP_RD: begin
                n_state = S_MAP_WR;
            end
            S_MAP_WR: begin
                pt_we    = 1'b1;
                pt_waddr = {r_p, r_idx[GW-1:0]};
                pt_wdata = {1'b1, ff_rdata};
                n_fhead  = r_fhead + 1'b1;
                n_fcnt   = r_fcnt - 1'b1;
                n_idx    = r_idx + 1'b1;
                n_state  = S_MAP_RD;
                if (r_idx == XW'(dpfm_pkg::ESS_COUNT - 1)) begin
                    n_act[r_p] = 1'b1;
                    e_valid    = 1'b1;
                    e_status   = (r_req == dpfm_pkg::REQ_ADMIT) ?
                                 dpfm_pkg::ST_ADMITTED : dpfm_pkg::ST_SWAPIN;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_pend   <= 1'b0;
            r_fhead  <= '0;
            r_fcnt   <= CW'(dpfm_pkg::NUM_FRAMES);
            r_swhead <= '0;
            r_swcnt  <= '0;
            r_act    <= '0;
            r_wait   <= '0;
            r_acc    <= '0;
            r_flt    <= '0;
            r_swp    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_pend   <= n_pend;
            r_fhead  <= n_fhead;
            r_fcnt   <= n_fcnt;
            r_swhead <= n_swhead;
            r_swcnt  <= n_swcnt;
            r_act    <= n_act;
            r_wait   <= n_wait;
            r_acc    <= n_acc;
            r_flt    <= n_flt;
            r_swp    <= n_swp;
            r_ov     <= e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_p     <= n_p;
        r_pg    <= n_pg;
        r_idx   <= n_idx;
        r_paddr <= n_paddr;
        if (swq_we) begin
            r_swq[r_swhead + r_swcnt[PW-1:0]] <= r_p;
        end
        if (e_valid) begin
            r_ost   <= e_status;
            r_op    <= e_proc;
            r_ofr   <= e_frame;
            r_olast <= e_last;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ost;
    assign o_proc_out     = dpfm_pkg::PROC_FW'(r_op);
    assign o_frame_out    = dpfm_pkg::FRAME_FW'(r_ofr);
    assign o_free_count   = dpfm_pkg::FCNT_FW'(r_fcnt);
    assign o_access_count = r_acc;
    assign o_fault_count  = r_flt;
    assign o_swap_count   = r_swp;
    assign o_last         = r_olast;

    a_fcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CW'(dpfm_pkg::NUM_FRAMES))
        else $error("free frame count out of range");
    a_swq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_swcnt <= QW'(dpfm_pkg::NUM_PROCS))
        else $error("swapped queue overflow");
    a_wait_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait & r_act) == '0)
        else $error("waiting process marked active");
    a_wait_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_wait) == int'(r_swcnt))
        else $error("waiting flags disagree with swapped queue fill");
endmodule
`default_nettype wire
